/* rtl/core/ecd_pkg.sv */
// Shared types, register codes and the weight-table builder for the
// EMA crossover detector. No dependencies.
package ecd_pkg;

    // Register indexes (byte address = 4 * index)
    localparam logic REG_SLOW_DECAY = 1'b0;
    localparam logic REG_FAST_DECAY = 1'b1;

    localparam logic [7:0] SLOW_DECAY_RST = 8'd1;
    localparam logic [7:0] FAST_DECAY_RST = 8'd10;

    // exp(-1) in Q0.32
    localparam logic [63:0] EXP_NEG1_Q32 = 64'd1580030169;

    // One-hot stage strobes from the controller to the datapath
    typedef struct packed {
        logic load;   // capture item, compute dt
        logic idx;    // decay * dt, differences
        logic wt;     // weight table read
        logic mul;    // weight multiply
        logic upd;    // average update, compare, result
    } t_dp_cmd;

    // Weight 1 - exp(-k) in Q1.w, evaluated at elaboration only.
    function automatic logic [32:0] weight_entry(input int unsigned k,
                                                 input int unsigned w);
        logic [63:0] e;
        logic [63:0] r;
        int unsigned i;
        e = 64'd1 << 32;
        for (i = 0; i < k; i++) begin
            e = (e * EXP_NEG1_Q32 + (64'd1 << 31)) >> 32;
        end
        r = (e + (64'd1 << (31 - w))) >> (32 - w);
        return 33'((64'd1 << w) - r);
    endfunction

endpackage

/* rtl/core/ecd_ctrl.sv */
// Sequencer for the EMA crossover detector: one item at a time through
// index, table, multiply and update stages. Uses ecd_pkg.
module ecd_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output ecd_pkg::t_dp_cmd o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_IDX  = 3'd1;
    localparam logic [2:0] S_WT   = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_UPD  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDX;
                end
            end
            S_IDX: begin
                o_cmd.idx = 1'b1;
                n_state   = S_WT;
            end
            S_WT: begin
                o_cmd.wt = 1'b1;
                n_state  = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_UPD;
            end
            S_UPD: begin
                // hold until the result slot is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.upd = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.upd) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

/* rtl/core/ecd_dp.sv */
// Datapath of the EMA crossover detector: dt, table index, weight lookup,
// weight multiply and average update. Uses ecd_pkg for commands and the table.
module ecd_dp #(
    parameter int TABLE_DEPTH      = 64,
    parameter int WEIGHT_FRAC_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ecd_pkg::t_dp_cmd i_cmd,
    input  logic [7:0]       i_slow_decay,
    input  logic [7:0]       i_fast_decay,
    input  logic [31:0]      i_sample_time,
    input  logic [31:0]      i_sample_value,
    output logic [31:0]      o_slow_average,
    output logic [31:0]      o_fast_average,
    output logic             o_cross_event,
    output logic             o_golden_cross
);

    localparam int W  = WEIGHT_FRAC_BITS;
    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int PW = W + 35;

    // constant weight table
    logic [W:0] w_table [TABLE_DEPTH];
    for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_tbl
        assign w_table[k] = (W+1)'(ecd_pkg::weight_entry(k, W));
    end

    logic [31:0]          r_x;
    logic [31:0]          r_dt;
    logic [31:0]          r_prev;
    logic [31:0]          r_slow;
    logic [31:0]          r_fast;
    logic                 r_seeded;
    logic                 r_last;
    logic                 r_cross;
    logic                 r_sat_s, r_sat_f;
    logic [IW-1:0]        r_idx_s, r_idx_f;
    logic signed [32:0]   r_diff_s, r_diff_f;
    logic [W:0]           r_w_s, r_w_f;
    logic signed [PW-1:0] r_p_s, r_p_f;

    logic [39:0]          idx_s, idx_f;
    logic signed [PW-1:0] q_s, q_f;
    logic [31:0]          n_slow, n_fast;
    logic                 golden;

    assign idx_s = {32'd0, i_slow_decay} * {8'd0, r_dt};
    assign idx_f = {32'd0, i_fast_decay} * {8'd0, r_dt};

    // round to nearest, ties up: floor((p + half) / 2^W)
    assign q_s = (r_p_s + (PW'(1) <<< (W - 1))) >>> W;
    assign q_f = (r_p_f + (PW'(1) <<< (W - 1))) >>> W;

    assign n_slow = r_seeded ? r_slow + q_s[31:0] : r_x;
    assign n_fast = r_seeded ? r_fast + q_f[31:0] : r_x;
    assign golden = $signed(n_slow) < $signed(n_fast);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x  <= i_sample_value;
            r_dt <= (i_sample_time > r_prev) ? i_sample_time - r_prev : 32'd0;
        end
        if (i_cmd.idx) begin
            r_sat_s  <= idx_s >= 40'(TABLE_DEPTH);
            r_sat_f  <= idx_f >= 40'(TABLE_DEPTH);
            r_idx_s  <= idx_s[IW-1:0];
            r_idx_f  <= idx_f[IW-1:0];
            r_diff_s <= $signed({r_x[31], r_x}) - $signed({r_slow[31], r_slow});
            r_diff_f <= $signed({r_x[31], r_x}) - $signed({r_fast[31], r_fast});
        end
        if (i_cmd.wt) begin
            r_w_s <= r_sat_s ? {1'b1, {W{1'b0}}} : w_table[r_idx_s];
            r_w_f <= r_sat_f ? {1'b1, {W{1'b0}}} : w_table[r_idx_f];
        end
        if (i_cmd.mul) begin
            r_p_s <= PW'(r_diff_s) * PW'($signed({1'b0, r_w_s}));
            r_p_f <= PW'(r_diff_f) * PW'($signed({1'b0, r_w_f}));
        end
        if (i_cmd.upd) begin
            r_cross <= !r_seeded || (golden != r_last);
        end
    end

    // stored state with reset values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev   <= 32'd0;
            r_slow   <= 32'd0;
            r_fast   <= 32'd0;
            r_seeded <= 1'b0;
            r_last   <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_prev <= i_sample_time;
            end
            if (i_cmd.upd) begin
                r_slow   <= n_slow;
                r_fast   <= n_fast;
                r_seeded <= 1'b1;
                r_last   <= golden;
            end
        end
    end

    assign o_slow_average = r_slow;
    assign o_fast_average = r_fast;
    assign o_cross_event  = r_cross;
    assign o_golden_cross = r_last;

endmodule

/* rtl/core/ema_crossover_detector.sv */
// The result is registered after the update stage and then raises m_axis_tvalid.
// The one-item sequencer takes a new item only after the previous one has finished its
// index multiply, weight table read, weight multiply and average update.
// A result waiting on m_axis_tready holds the update stage only.
// Reset (synchronous, i_rst_n low): averages, previous time and seed flag
// cleared, slow_decay = 1, fast_decay = 10.
module ema_crossover_detector #(
    parameter int TABLE_DEPTH      = 64,
    parameter int WEIGHT_FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] sample_time, [63:32] sample_value
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [31:0] slow_average, [63:32] fast_average
    output logic [1:0]  m_axis_tuser,   // [0] cross_event, [1] golden_cross
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0]       r_slow_decay;
    logic [7:0]       r_fast_decay;
    ecd_pkg::t_dp_cmd cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slow_decay <= ecd_pkg::SLOW_DECAY_RST;
            r_fast_decay <= ecd_pkg::FAST_DECAY_RST;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == ecd_pkg::REG_SLOW_DECAY) begin
                r_slow_decay <= pwdata[7:0];
            end else begin
                r_fast_decay <= pwdata[7:0];
            end
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == ecd_pkg::REG_SLOW_DECAY) ? {24'd0, r_slow_decay}
                                                          : {24'd0, r_fast_decay};

    ecd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd)
    );

    ecd_dp #(
        .TABLE_DEPTH      (TABLE_DEPTH),
        .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_slow_decay   (r_slow_decay),
        .i_fast_decay   (r_fast_decay),
        .i_sample_time  (s_axis_tdata[31:0]),
        .i_sample_value (s_axis_tdata[63:32]),
        .o_slow_average (m_axis_tdata[31:0]),
        .o_fast_average (m_axis_tdata[63:32]),
        .o_cross_event  (m_axis_tuser[0]),
        .o_golden_cross (m_axis_tuser[1])
    );

endmodule

/* rtl/core/ecd_checker.sv */
// Port-level checks for the EMA crossover detector, bound to the top level.
// Depends on ema_crossover_detector only through its port names.
module ecd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [63:0] s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // one item in flight: no accept in the cycle after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted back to back");

    // no result can appear sooner than the pipeline allows
    a_no_early_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("result before its item was processed");

    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready && pready)
        else $error("bad state after reset");

endmodule

bind ema_crossover_detector ecd_checker u_ecd_checker (.*);

/* test/testbench.sv */
// Self-checking testbench for ema_crossover_detector: streams timestamped samples,
// predicts both averages and the cross flags per item, and checks every result.
// Depends on ecd_pkg and the ema_crossover_detector RTL only.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RUN_LIMIT     = 400000;
    localparam int ITEMS_PER_SET = 230;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 20;

    typedef struct {
        bit [31:0] slow_avg;
        bit [31:0] fast_avg;
        bit        cross_event;
        bit        golden;
    } t_ema_result;

    // Tracks both averages and the last slow/fast comparison.
    class t_crossover_tracker;
        bit [7:0]    slow_decay;
        bit [7:0]    fast_decay;
        bit          seeded;
        bit [31:0]   last_stamp;
        longint      slow_avg;
        longint      fast_avg;
        bit          compare_seen;
        bit          last_golden;
        bit [16:0]   alpha_lut[64];
        t_ema_result pending_results[$];
        int          fails;

        function new();
            longint unsigned e;
            longint unsigned r;
            e = 64'd1 << 32;
            for (int k = 0; k < 64; k++) begin
                r = (e + (64'd1 << 15)) >> 16;
                alpha_lut[k] = 17'((64'd1 << 16) - r);
                e = (e * ecd_pkg::EXP_NEG1_Q32 + (64'd1 << 31)) >> 32;
            end
            slow_decay   = ecd_pkg::SLOW_DECAY_RST;
            fast_decay   = ecd_pkg::FAST_DECAY_RST;
            seeded       = 0;
            last_stamp   = 0;
            slow_avg     = 0;
            fast_avg     = 0;
            compare_seen = 0;
            last_golden  = 0;
            fails        = 0;
        endfunction

        function void set_decay(logic idx, bit [7:0] val);
            if (idx == ecd_pkg::REG_SLOW_DECAY) begin
                slow_decay = val;
            end else begin
                fast_decay = val;
            end
        endfunction

        function bit [16:0] alpha_for(bit [7:0] decay, longint unsigned dt);
            longint unsigned pos;
            pos = longint'(decay) * dt;
            if (pos >= 64) begin
                return 17'h10000;
            end
            return alpha_lut[pos];
        endfunction

        // avg + round(w * (x - avg) / 2^16), ties toward +inf
        function longint blend_toward(longint avg, longint x, bit [16:0] w);
            longint p;
            p = (x - avg) * longint'(w);
            return avg + ((p + 64'sd32768) >>> 16);
        endfunction

        function void note_sample(bit [31:0] stamp, bit [31:0] value);
            longint          x;
            longint unsigned dt;
            t_ema_result     res;
            x = longint'($signed(value));
            if (!seeded) begin
                slow_avg = x;
                fast_avg = x;
                seeded   = 1;
            end else begin
                dt = (stamp > last_stamp) ? longint'(stamp - last_stamp) : 0;
                slow_avg = blend_toward(slow_avg, x, alpha_for(slow_decay, dt));
                fast_avg = blend_toward(fast_avg, x, alpha_for(fast_decay, dt));
            end
            last_stamp      = stamp;
            res.golden      = slow_avg < fast_avg;
            res.cross_event = !compare_seen || (res.golden != last_golden);
            compare_seen    = 1;
            last_golden     = res.golden;
            res.slow_avg    = slow_avg[31:0];
            res.fast_avg    = fast_avg[31:0];
            pending_results.push_back(res);
        endfunction

        function void check_result(logic [63:0] data, logic [1:0] user);
            t_ema_result want;
            if (pending_results.size() == 0) begin
                $error("unexpected result: tdata %h tuser %b", data, user);
                fails++;
                return;
            end
            want = pending_results.pop_front();
            if (data[31:0] !== want.slow_avg) begin
                $error("slow_average: expected %h, got %h", want.slow_avg, data[31:0]);
                fails++;
            end
            if (data[63:32] !== want.fast_avg) begin
                $error("fast_average: expected %h, got %h", want.fast_avg, data[63:32]);
                fails++;
            end
            if (user[0] !== want.cross_event) begin
                $error("cross_event: expected %b, got %b", want.cross_event, user[0]);
                fails++;
            end
            if (user[1] !== want.golden) begin
                $error("golden_cross: expected %b, got %b", want.golden, user[1]);
                fails++;
            end
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;   // [31:0] sample_time, [63:32] sample_value
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [63:0] m_axis_tdata;        // [31:0] slow_average, [63:32] fast_average
    logic [1:0]  m_axis_tuser;        // [0] cross_event, [1] golden_cross
    logic        psel = 0;
    logic        penable = 0;
    logic        pwrite = 0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    ema_crossover_detector dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    t_crossover_tracker tracker = new();

    int        cycle_count = 0;
    logic      hold_req = 0;
    bit [31:0] stamp_now = 0;
    int        level = 0;
    int        trend = 0;
    int        burst_left = 1;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > RUN_LIMIT) begin
            $display("ema_crossover_detector regression: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            tracker.check_result(m_axis_tdata, m_axis_tuser);
        end
    end

    // Output back-pressure: pattern picked from cycle_count[9:8], plus one long hold.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                m_axis_tready <= 0;
                hold_req <= 0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                case (cycle_count[9:8])
                    2'd0: m_axis_tready <= 1;
                    2'd1: m_axis_tready <= $urandom_range(0, 1);
                    2'd2: m_axis_tready <= (cycle_count[1:0] != 2'd0);
                    default: m_axis_tready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    task automatic apb_write(logic idx, bit [7:0] val);
        bit [31:0] junk;
        junk = $urandom();
        psel    <= 1;
        pwrite  <= 1;
        penable <= 0;
        paddr   <= {idx, 2'b00};
        pwdata  <= {junk[31:8], val};
        @(posedge i_clk);
        penable <= 1;
        do @(posedge i_clk); while (!pready);
        psel    <= 0;
        penable <= 0;
        tracker.set_decay(idx, val);
    endtask

    task automatic apb_check(logic idx, bit [7:0] val);
        psel    <= 1;
        pwrite  <= 0;
        penable <= 0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1;
        do @(posedge i_clk); while (!pready);
        if (prdata[7:0] !== val) begin
            $error("decay register %0d: expected %h, got %h", idx, val, prdata[7:0]);
            tracker.fails++;
        end
        psel    <= 0;
        penable <= 0;
    endtask

    task automatic send_sample(bit [31:0] stamp, bit [31:0] value);
        s_axis_tvalid <= 1;
        s_axis_tdata  <= {value, stamp};
        do @(posedge i_clk); while (!s_axis_tready);
        tracker.note_sample(stamp, value);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 0;
        while (tracker.pending() != 0) @(posedge i_clk);
    endtask

    // Mostly small forward steps around a drifting level, so the averages
    // cross often; the rest is stalled/backward time, wild values and extremes.
    task automatic next_random_sample(output bit [31:0] stamp, output bit [31:0] value);
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            stamp_now += ($urandom_range(0, 3) == 0) ? $urandom_range(0, 80)
                                                     : $urandom_range(0, 9);
        end else if (r < 80) begin
            stamp_now = stamp_now;
        end else if (r < 88) begin
            stamp_now -= $urandom_range(1, 1000);
        end else if (r < 94) begin
            stamp_now = $urandom();
        end else begin
            stamp_now += $urandom_range(100, 1 << 20);
        end
        stamp = stamp_now;

        if ($urandom_range(0, 19) == 0) begin
            trend = int'($urandom_range(0, 1 << 17)) - (1 << 16);
        end
        level += trend + int'($urandom_range(0, 1 << 15)) - (1 << 14);
        if (level > (1 << 30) || level < -(1 << 30)) begin
            level = 0;
            trend = -trend;
        end
        r = $urandom_range(0, 99);
        if (r < 75) begin
            value = level + int'($urandom_range(0, 1 << 17)) - (1 << 16);
        end else if (r < 87) begin
            value = $urandom();
        end else if (r < 95) begin
            case ($urandom_range(0, 3))
                0: value = 32'h7FFF_FFFF;
                1: value = 32'h8000_0000;
                2: value = 32'h0000_0000;
                default: value = 32'hFFFF_FFFF;
            endcase
        end else begin
            value = -level;
        end
    endtask

    task automatic send_random_set(int count, int set_no);
        bit [31:0] stamp;
        bit [31:0] value;
        for (int n = 0; n < count; n++) begin
            if (set_no == 2 && n == 60) begin
                hold_req <= 1;
            end
            if (set_no == 4 && n == 100) begin
                wait_drained();
            end
            next_random_sample(stamp, value);
            send_sample(stamp, value);
            burst_left--;
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                s_axis_tvalid <= 0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    endtask

    initial begin
        bit [7:0]  slow_set[8];
        bit [7:0]  fast_set[8];
        bit [31:0] dir_stamp[$];
        bit [31:0] dir_value[$];

        slow_set = '{ecd_pkg::SLOW_DECAY_RST, 0, 255, 0, 255, 2, 0, 0};
        fast_set = '{ecd_pkg::FAST_DECAY_RST, 0, 255, 255, 0, 17, 0, 0};
        slow_set[6] = $urandom_range(1, 40);
        fast_set[6] = $urandom_range(1, 64);
        slow_set[7] = $urandom_range(0, 255);
        fast_set[7] = $urandom_range(0, 255);

        // seed at max, time standing still, time backwards, one tick with
        // full-scale swing, jump past the table, wrap to zero, the last table
        // entry and the first one past it, then a rise and a fall for crosses
        dir_stamp = '{100, 100, 50, 51, 200, 32'hFFFF_FFFF, 0, 63, 127,
                      128, 129, 130, 131, 132, 133};
        dir_value = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0001_0000,
                      32'h0000_0000, 32'h0004_0000, 32'h0008_0000, 32'h0010_0000,
                      32'hFFF0_0000, 32'hFFE0_0000, 32'hFFC0_0000};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        for (int set_no = 0; set_no < 8; set_no++) begin
            wait_drained();
            apb_write(ecd_pkg::REG_SLOW_DECAY, slow_set[set_no]);
            apb_write(ecd_pkg::REG_FAST_DECAY, fast_set[set_no]);
            apb_check(ecd_pkg::REG_SLOW_DECAY, slow_set[set_no]);
            apb_check(ecd_pkg::REG_FAST_DECAY, fast_set[set_no]);
            if (set_no == 0) begin
                foreach (dir_stamp[i]) begin
                    send_sample(dir_stamp[i], dir_value[i]);
                end
                stamp_now = dir_stamp[dir_stamp.size() - 1];
            end
            send_random_set(ITEMS_PER_SET, set_no);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.fails == 0) begin
            $display("ema_crossover_detector regression: pass");
        end else begin
            $display("ema_crossover_detector regression: fail");
        end
        $finish;
    end
endmodule
